FILE: rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// Targa RLE pixel decoder package
// Shared types and constants for the decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BPP   = 2'd0;
    localparam logic [1:0] CFG_RLE   = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    localparam int unsigned CNT_W  = 23;
    localparam int unsigned IDX_W  = 22;

    localparam int unsigned RUN_BIT       = 7;
    localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
    localparam logic [2:0]  BPP_THREE     = 3'd3;

    // One decoded pixel request, passed from the front end to the back end.
    typedef struct packed {
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic [7:0]       byte2;
        logic [7:0]       byte_fin;
        logic             bpp3;
        logic [IDX_W-1:0] first_pixel;
        logic [7:0]       repeat_cnt;
        logic             last;
        logic             overrun;
    } t_pix_req;

endpackage

FILE: rtl/tgarle_front.sv
// ----------------------------------------------------------------------------
// Targa RLE decoder front end
// Holds the configuration, parses packet headers and gathers pixel bytes.
// ----------------------------------------------------------------------------
module tgarle_front #(
    parameter logic [31:0] P_MAX_PIXELS = 32'd4194304
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [22:0]           i_cfg_data,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_q_full,
    output logic                  o_push,
    output tgarle_pkg::t_pix_req  o_req
);
    import tgarle_pkg::*;

    logic [2:0]       r_bpp;
    logic             r_rle;
    logic [CNT_W-1:0] r_total;
    logic             r_expect_header;
    logic             r_packet_is_run;
    logic [7:0]       r_packet_left;
    logic [1:0]       r_byte_slot;
    logic [23:0]      r_colour;
    logic [CNT_W-1:0] r_pixels_done;

    logic [7:0]       n_packet_left;
    logic             accept;
    logic             done;
    logic             header;
    logic             bpp3;
    logic [1:0]       last_slot;
    logic             pixel_end;
    logic             is_run;
    logic             over;
    logic [CNT_W-1:0] remaining;
    logic [7:0]       rep;
    logic [CNT_W-1:0] new_done;
    logic [CNT_W-1:0] cfg_total;
    logic             cfg_hit;

    // The image size is clamped once, when it is written.
    assign cfg_total = ({9'd0, i_cfg_data} > P_MAX_PIXELS) ? P_MAX_PIXELS[CNT_W-1:0]
                                                            : i_cfg_data;

    // Only writes to an existing register restart decoding.
    assign cfg_hit   = i_cfg_valid && ((i_cfg_index == CFG_BPP) ||
                                       (i_cfg_index == CFG_RLE) ||
                                       (i_cfg_index == CFG_COUNT));

    assign accept    = i_in_valid && !i_q_full;
    assign done      = (r_pixels_done >= r_total);
    assign header    = r_rle && r_expect_header;
    assign bpp3      = (r_bpp == BPP_THREE);
    assign last_slot = bpp3 ? 2'd2 : 2'd3;
    assign pixel_end = !done && !header && (r_byte_slot == last_slot);

    assign remaining = r_total - r_pixels_done;
    assign is_run    = r_rle && r_packet_is_run;
    assign over      = is_run && ({15'd0, r_packet_left} > remaining);
    assign rep       = !is_run ? 8'd1 : (over ? remaining[7:0] : r_packet_left);
    assign new_done  = r_pixels_done + {15'd0, rep};

    always_comb begin
        if (is_run) begin
            n_packet_left = 8'd0;
        end else if (r_rle && (r_packet_left != 8'd0)) begin
            n_packet_left = r_packet_left - 8'd1;
        end else begin
            n_packet_left = r_packet_left;
        end
    end

    assign o_push = accept && pixel_end;

    always_comb begin
        o_req.byte0       = r_colour[7:0];
        o_req.byte1       = r_colour[15:8];
        o_req.byte2       = r_colour[23:16];
        o_req.byte_fin    = i_data_byte;
        o_req.bpp3        = bpp3;
        o_req.first_pixel = r_pixels_done[IDX_W-1:0];
        o_req.repeat_cnt  = rep;
        o_req.last        = (new_done >= r_total);
        o_req.overrun     = over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp           <= 3'd4;
            r_rle           <= 1'b1;
            r_total         <= 23'd1;
            r_expect_header <= 1'b1;
            r_packet_is_run <= 1'b0;
            r_packet_left   <= 8'd0;
            r_byte_slot     <= 2'd0;
            r_colour        <= 24'd0;
            r_pixels_done   <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                CFG_BPP:   r_bpp   <= i_cfg_data[2:0];
                CFG_RLE:   r_rle   <= i_cfg_data[0];
                CFG_COUNT: r_total <= cfg_total;
                default:   r_bpp   <= r_bpp;
            endcase
            r_expect_header <= (i_cfg_index == CFG_RLE) ? i_cfg_data[0] : r_rle;
            r_packet_is_run <= 1'b0;
            r_packet_left   <= 8'd0;
            r_byte_slot     <= 2'd0;
            r_colour        <= 24'd0;
            r_pixels_done   <= '0;
        end else if (accept && !done) begin
            if (header) begin
                r_packet_is_run <= i_data_byte[RUN_BIT];
                r_packet_left   <= {1'b0, i_data_byte[6:0]} + 8'd1;
                r_expect_header <= 1'b0;
                r_byte_slot     <= 2'd0;
            end else if (!pixel_end) begin
                case (r_byte_slot)
                    2'd0:    r_colour[7:0]   <= i_data_byte;
                    2'd1:    r_colour[15:8]  <= i_data_byte;
                    default: r_colour[23:16] <= i_data_byte;
                endcase
                r_byte_slot <= r_byte_slot + 2'd1;
            end else begin
                r_colour        <= 24'd0;
                r_byte_slot     <= 2'd0;
                r_packet_left   <= n_packet_left;
                r_pixels_done   <= new_done;
                if (r_rle && (n_packet_left == 8'd0)) begin
                    r_expect_header <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/tgarle_queue.sv
// ----------------------------------------------------------------------------
// Targa RLE decoder request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tgarle_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tgarle_pkg::t_pix_req  i_req,
    input  logic                  i_pop,
    output logic                  o_valid,
    output tgarle_pkg::t_pix_req  o_req,
    output logic                  o_full
);
    import tgarle_pkg::*;

    t_pix_req   r_slot0;
    t_pix_req   r_slot1;
    logic [1:0] r_cnt;
    logic [1:0] wr_pos;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_req   = r_slot0;
    assign pop     = i_pop && o_valid;
    assign wr_pos  = pop ? (r_cnt - 2'd1) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    // Pushes only arrive while the queue has room.
    always_ff @(posedge i_clk) begin
        if (pop && (r_cnt == 2'd2)) begin
            r_slot0 <= r_slot1;
        end
        if (i_push) begin
            if (wr_pos == 2'd0) begin
                r_slot0 <= i_req;
            end else begin
                r_slot1 <= i_req;
            end
        end
    end

endmodule

FILE: rtl/tgarle_back.sv
// ----------------------------------------------------------------------------
// Targa RLE decoder back end
// Reorders each pixel to RGBA and holds the result in the output register.
// ----------------------------------------------------------------------------
module tgarle_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  tgarle_pkg::t_pix_req  i_req,
    output logic                  o_pop,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_alpha,
    output logic [21:0]           o_first_pixel,
    output logic [7:0]            o_repeat_res,
    output logic                  o_last,
    output logic                  o_overrun
);
    import tgarle_pkg::*;

    logic        r_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_alpha;
    logic [21:0] r_first;
    logic [7:0]  r_repeat;
    logic        r_last;
    logic        r_overrun;
    logic        load;

    assign load  = i_q_valid && (!r_valid || !i_out_stall);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_blue    <= i_req.byte0;
            r_green   <= i_req.byte1;
            r_red     <= i_req.bpp3 ? i_req.byte_fin : i_req.byte2;
            r_alpha   <= i_req.bpp3 ? ALPHA_OPAQUE : i_req.byte_fin;
            r_first   <= i_req.first_pixel;
            r_repeat  <= i_req.repeat_cnt;
            r_last    <= i_req.last;
            r_overrun <= i_req.overrun;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_alpha       = r_alpha;
    assign o_first_pixel = r_first;
    assign o_repeat_res  = r_repeat;
    assign o_last        = r_last;
    assign o_overrun     = r_overrun;

endmodule

FILE: rtl/tga_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// Targa RLE pixel decoder
// Decodes 24/32-bit Targa pixel data, one byte per cycle, into RGBA requests.
// ----------------------------------------------------------------------------
// The decoder takes one byte of pixel data per clock cycle, sustained, for as
// long as the output side keeps up. The front end parses packet headers and
// gathers the B, G, R (and A) bytes of a pixel; on the final byte of a pixel it
// pushes one request into a two-entry queue. The back end reorders it to RGBA
// and holds it in the output register; a result reaches the output ports
// once it has passed from the queue into that register. A run packet comes
// out as one request with its repeat count, and each literal or raw pixel
// as its own request. The queue lets the input keep streaming for two more
// pixels while the output is stalled; after that the input stall rises. A
// run that would pass the end of the image is cut to the remaining pixels
// and flagged with overrun and last. Once the image is complete, further
// bytes are accepted and dropped. Any configuration write to an existing
// register restarts decoding; writes should only be made while no request
// is pending.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit #(
    parameter logic [31:0] MAX_PIXELS = 32'd4194304
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    // Pixel result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [21:0] o_first_pixel,
    output logic [7:0]  o_repeat_res,
    output logic        o_last,
    output logic        o_overrun
);
    import tgarle_pkg::*;

    t_pix_req front_req;
    t_pix_req queue_req;
    logic     push;
    logic     q_valid;
    logic     q_full;
    logic     pop;

    // Configuration writes are always taken at once.
    assign o_cfg_ready = 1'b1;
    // The input stalls only when the queue has no room left.
    assign o_in_stall  = q_full;

    tgarle_front #(
        .P_MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_req       (front_req)
    );

    tgarle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_req   (queue_req),
        .o_full  (q_full)
    );

    tgarle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_req         (queue_req),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_first_pixel (o_first_pixel),
        .o_repeat_res  (o_repeat_res),
        .o_last        (o_last),
        .o_overrun     (o_overrun)
    );

endmodule

FILE: rtl/tgarle_checker.sv
// ----------------------------------------------------------------------------
// Targa RLE decoder port checker
// Watches the decoder ports for result and reset consistency.
// ----------------------------------------------------------------------------
module tgarle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [7:0]  o_alpha,
    input logic [21:0] o_first_pixel,
    input logic [7:0]  o_repeat_res,
    input logic        o_last,
    input logic        o_overrun
);

    // A stalled result request holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red) &&
        $stable(o_green) && $stable(o_blue) && $stable(o_alpha) &&
        $stable(o_first_pixel) && $stable(o_repeat_res) && $stable(o_last) &&
        $stable(o_overrun))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Every result covers between one and one hundred twenty-eight pixels.
    a_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_repeat_res != 8'd0) && (o_repeat_res <= 8'd128))
        else $error("repeat count out of range");

    // A truncated run always ends the image.
    a_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overrun |-> o_last)
        else $error("overrun without last");

endmodule

bind tga_rle_pixel_decoder_unit tgarle_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_alpha       (o_alpha),
    .o_first_pixel (o_first_pixel),
    .o_repeat_res  (o_repeat_res),
    .o_last        (o_last),
    .o_overrun     (o_overrun)
);

FILE: test/tga_rle_pixel_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// Targa RLE pixel decoder testbench
// Streams Targa pixel bytes (run, literal and raw) through the decoder under
// random idling and output stalls, and checks every pixel request against an
// in-bench decoder that tracks packet state, pixel position and image end.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit_tb;
    import tgarle_pkg::*;

    // Default image size limit of the decoder, and the unused register index.
    localparam int unsigned PIXEL_LIMIT  = 4194304;
    localparam logic [1:0]  CFG_SPARE    = 2'd3;
    localparam int unsigned RANDOM_BYTES = 1800;
    // A completed pixel passes through the queue and the output register; this
    // wait lets the decoder settle once nothing is expected.
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef logic [7:0] byte_q_t[$];

    // One expected or observed pixel request.
    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [21:0] first_pixel;
        logic [7:0]  repeat_res;
        logic        last;
        logic        overrun;
    } pixel_t;

    // Keeps its own copy of the registers and the packet state, decodes every
    // accepted byte, and holds the pixel requests that must still come out.
    class rgba_scoreboard;
        logic [2:0]  pix_bytes;
        logic        rle_on;
        logic [22:0] image_pixels;
        logic        want_header;
        logic        run_packet;
        int unsigned packet_remain;
        int unsigned slot;
        int unsigned pixels_out;
        logic [23:0] colour_acc;
        pixel_t      pending_pixels[$];
        int unsigned errors;

        function new();
            pix_bytes    = 3'd4;
            rle_on       = 1'b1;
            image_pixels = 23'd1;
            errors       = 0;
            restart();
        endfunction

        function void restart();
            want_header   = rle_on;
            run_packet    = 1'b0;
            packet_remain = 0;
            slot          = 0;
            colour_acc    = '0;
            pixels_out    = 0;
        endfunction

        function int unsigned image_size();
            return (image_pixels > PIXEL_LIMIT) ? PIXEL_LIMIT : image_pixels;
        endfunction

        // Any write to a real register restarts decoding; the spare index
        // leaves everything alone.
        function void write_register(logic [1:0] index, logic [22:0] data);
            case (index)
                CFG_BPP:   pix_bytes = data[2:0];
                CFG_RLE:   rle_on = data[0];
                CFG_COUNT: image_pixels = data;
                default:   return;
            endcase
            restart();
        endfunction

        function void decode_byte(logic [7:0] b);
            int unsigned bpp_n;
            int unsigned total;
            int unsigned remaining;
            int unsigned rep;
            pixel_t      px;
            bpp_n = (pix_bytes == BPP_THREE) ? 3 : 4;
            total = image_size();
            if (pixels_out >= total) return;
            if (rle_on && want_header) begin
                run_packet    = b[RUN_BIT];
                packet_remain = b[6:0] + 1;
                want_header   = 1'b0;
                slot          = 0;
                return;
            end
            if (slot < bpp_n - 1) begin
                colour_acc = colour_acc | (24'(b) << (8 * slot));
                slot++;
                return;
            end
            // Final byte of the pixel: stored order is B, G, R, A.
            px.blue  = colour_acc[7:0];
            px.green = colour_acc[15:8];
            if (bpp_n == 3) begin
                px.red   = b;
                px.alpha = ALPHA_OPAQUE;
            end else begin
                px.red   = colour_acc[23:16];
                px.alpha = b;
            end
            colour_acc = '0;
            slot       = 0;
            remaining  = total - pixels_out;
            px.overrun = 1'b0;
            if (rle_on && run_packet) begin
                rep = packet_remain;
                if (rep > remaining) begin
                    rep        = remaining;
                    px.overrun = 1'b1;
                end
                packet_remain = 0;
            end else begin
                rep = 1;
                if (rle_on && packet_remain > 0) packet_remain--;
            end
            if (rle_on && packet_remain == 0) want_header = 1'b1;
            px.first_pixel = pixels_out[21:0];
            px.repeat_res  = rep[7:0];
            pixels_out += rep;
            px.last = (pixels_out >= total);
            pending_pixels.push_back(px);
        endfunction

        function void field_check(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                $error("pixel request with none expected: first_pixel %0d",
                       got.first_pixel);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            field_check("red", want.red, got.red);
            field_check("green", want.green, got.green);
            field_check("blue", want.blue, got.blue);
            field_check("alpha", want.alpha, got.alpha);
            field_check("first_pixel", want.first_pixel, got.first_pixel);
            field_check("repeat_res", want.repeat_res, got.repeat_res);
            field_check("last", want.last, got.last);
            field_check("overrun", want.overrun, got.overrun);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [22:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [21:0] o_first_pixel;
    logic [7:0]  o_repeat_res;
    logic        o_last;
    logic        o_overrun;

    rgba_scoreboard sb;
    int unsigned    bytes_sent = 0;
    // Set while the byte channel holds valid high from one request to the next.
    bit             in_held = 1'b0;
    // While a side is calm it never idles, so back-to-back traffic and a full
    // internal queue are reached as well as sparse traffic.
    bit             in_calm = 1'b0;
    bit             out_calm = 1'b0;

    tga_rle_pixel_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_first_pixel (o_first_pixel),
        .o_repeat_res  (o_repeat_res),
        .o_last        (o_last),
        .o_overrun     (o_overrun)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Every so often a side flips between calm and idling; when idling it
    // draws a random wait before each request.
    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(0, 49) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Presents one byte and waits for the decoder to take it. Valid is only
    // dropped when an idle gap follows, so a streaming run keeps it high.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            if (in_held) i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= value;
        in_held = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.decode_byte(value);
        bytes_sent++;
    endtask

    task automatic send_list(input byte_q_t seq);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic send_pixel(input int unsigned bpp_n);
        repeat (bpp_n) send_byte(8'($urandom));
    endtask

    task automatic release_input();
        if (in_held) begin
            i_in_valid <= 1'b0;
            in_held = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes are only made once the decoder has gone quiet, since a
    // write restarts decoding and would drop a partly gathered pixel.
    task automatic write_reg(input logic [1:0] index, input logic [22:0] data);
        release_input();
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_register(index, data);
    endtask

    // One random image: new settings, then a well-formed packet stream with
    // random colours that stops at the image end or when the byte budget runs
    // out, possibly mid-packet, sometimes followed by a few stray bytes.
    task automatic random_phase();
        logic [22:0] d;
        int unsigned bpp_n;
        int unsigned eff;
        int unsigned covered;
        int unsigned budget;
        int unsigned start;
        int unsigned n;
        logic [6:0]  len;
        logic        run;
        if ($urandom_range(0, 1) == 1) begin
            d = 23'($urandom);
            // Mostly legal pixel sizes; now and then an odd one.
            if ($urandom_range(0, 7) != 0) d[2:0] = $urandom_range(0, 1) ? 3'd3 : 3'd4;
            write_reg(CFG_BPP, d);
        end
        if ($urandom_range(0, 1) == 1) begin
            d = 23'($urandom);
            d[0] = ($urandom_range(0, 3) != 0);
            write_reg(CFG_RLE, d);
        end
        if ($urandom_range(0, 15) == 0) write_reg(CFG_SPARE, 23'($urandom));
        case ($urandom_range(0, 19))
            0:       d = 23'd0;
            1:       d = $urandom_range(0, 1) ? 23'h7FFFFF : 23'($urandom_range(4194305, 8388607));
            2:       d = $urandom_range(0, 1) ? 23'(PIXEL_LIMIT) : 23'($urandom);
            default: d = 23'($urandom_range(1, 60));
        endcase
        write_reg(CFG_COUNT, d);

        bpp_n   = (sb.pix_bytes == BPP_THREE) ? 3 : 4;
        eff     = sb.image_size();
        budget  = $urandom_range(40, 250);
        covered = 0;
        start   = bytes_sent;
        if (eff == 0) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        while (covered < eff && bytes_sent - start < budget) begin
            if (sb.rle_on) begin
                run = $urandom_range(0, 1);
                len = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 7));
                send_byte({run, len});
                n = len + 1;
                if (run) begin
                    send_pixel(bpp_n);
                    covered += n;
                end else begin
                    while (n > 0 && covered < eff && bytes_sent - start < budget) begin
                        send_pixel(bpp_n);
                        covered++;
                        n--;
                    end
                end
            end else begin
                send_pixel(bpp_n);
                covered++;
            end
        end
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    endtask

    // Output side: stall for a drawn number of cycles, then stay ready until
    // one pixel request has been taken.
    initial begin
        int unsigned hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = draw_wait(out_calm);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Pixel requests are sampled at the edge that takes them.
    always @(posedge i_clk) begin
        pixel_t seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.red         = o_red;
            seen.green       = o_green;
            seen.blue        = o_blue;
            seen.alpha       = o_alpha;
            seen.first_pixel = o_first_pixel;
            seen.repeat_res  = o_repeat_res;
            seen.last        = o_last;
            seen.overrun     = o_overrun;
            sb.check_pixel(seen);
        end
    end

    initial begin
        int unsigned directed_end;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the image is one 4-byte pixel in RLE mode. A run of 128
        // is cut to that single pixel and flagged; the byte after it lands on
        // a finished image and is dropped.
        send_list('{8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h12});

        // Four 3-byte pixels: a one-pixel literal packet, a run of two, then a
        // literal packet of 128 that runs past the image end.
        write_reg(CFG_BPP, 23'd3);
        write_reg(CFG_COUNT, 23'd4);
        send_list('{8'h00, 8'h01, 8'h02, 8'h03,
                    8'h81, 8'hFE, 8'hFD, 8'hFC,
                    8'h7F, 8'h40, 8'h50, 8'h60, 8'h99});

        // Raw mode with an odd pixel size, which acts as four bytes. A write to
        // the spare index in the middle must not restart the image.
        write_reg(CFG_RLE, 23'h7FFFFE);
        write_reg(CFG_BPP, 23'h7FFFFF);
        write_reg(CFG_COUNT, 23'd2);
        send_list('{8'h3C, 8'hC3, 8'h00, 8'hFF});
        write_reg(CFG_SPARE, 23'h2AAAAA);
        send_list('{8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h77});
        directed_end = bytes_sent;

        while (bytes_sent < directed_end + RANDOM_BYTES) random_phase();

        release_input();
        wait_drained();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop in case the decoder hangs.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
